/* sv/assert_macros.svh */
// Assertion macros shared by the RTL of the path traversal check unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high
`define CHK_SAME(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (b)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled while reset is high
`define CHK_NEXT(lbl, a, b, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (b)) \
      else $error(msg);

`endif

/* sv/uptc_pkg.sv */
// Types and constants for the path traversal check unit
package uptc_pkg;

   localparam int DEPTH_BITS     = 16;
   localparam int FD_BITS        = 16;
   localparam int WIDE_BITS      = (DEPTH_BITS > FD_BITS) ? DEPTH_BITS : FD_BITS;
   localparam int CHAR_BITS      = 8;
   localparam int VERDICT_BITS   = 2;
   localparam int RSP_FIELD_BITS = VERDICT_BITS + FD_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_BITS-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_BITS-1:0] CHAR_SLASH = 8'h2F;

   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX   = {1'b0, {(DEPTH_BITS-1){1'b1}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN   = {1'b1, {(DEPTH_BITS-1){1'b0}}};
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_START = '1;

   localparam logic signed [WIDE_BITS-1:0] FD_MAX_WIDE =
      WIDE_BITS'({1'b0, {(FD_BITS-1){1'b1}}});
   localparam logic signed [WIDE_BITS-1:0] FD_MIN_WIDE =
      -FD_MAX_WIDE - WIDE_BITS'(1);

   typedef enum logic [1:0] {
      SEG_EMPTY  = 2'd0,
      SEG_DOT    = 2'd1,
      SEG_DOTDOT = 2'd2,
      SEG_OTHER  = 2'd3
   } seg_class_type;

   typedef enum logic [1:0] {
      PH_FIRST    = 2'd0,
      PH_SLASH    = 2'd1,
      PH_SLASHDOT = 2'd2,
      PH_DONE     = 2'd3
   } prefix_phase_type;

   typedef enum logic [VERDICT_BITS-1:0] {
      VERDICT_ACCEPT  = 2'd0,
      VERDICT_REWRITE = 2'd1,
      VERDICT_REJECT  = 2'd2
   } verdict_type;

endpackage

/* sv/uri_path_traversal_check_unit.sv */
// Top level: byte-stream path checker for directory escape
//
// A request path enters on the req_ stream, one byte per beat; a zero byte
// ends the path. Each path yields exactly one beat on the rsp_ stream with
// the verdict (accept, rewrite to root, reject) and the final segment depth.
// Non-terminating bytes yield no output beat.
// A terminator enters the byte register and, once the result register is
// free, loads its verdict there. One byte per cycle unless a terminator
// waits; set by the single byte register and the one-entry result register.
// Reset (synchronous, active high) clears the path state to an empty path
// at depth -1 and drops any pending input or result beat.
// When the receiver holds rsp_tready low, the result beat waits in its
// register; bytes of the next path keep flowing until its terminator
// reaches the byte register, which then holds and deasserts req_tready.
`include "assert_macros.svh"

module uri_path_traversal_check_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [uptc_pkg::CHAR_BITS-1:0]       req_tdata,  // [7:0] path_char
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [uptc_pkg::RSP_TDATA_BITS-1:0]  rsp_tdata   // [1:0] verdict, [17:2] final_depth
);

   // input byte register
   logic                            byte_valid_ff, byte_valid_in;
   logic [uptc_pkg::CHAR_BITS-1:0]  byte_ff, byte_in;

   // path state
   logic signed [uptc_pkg::DEPTH_BITS-1:0] depth_ff, depth_in;
   uptc_pkg::seg_class_type                seg_ff, seg_in;
   uptc_pkg::prefix_phase_type             phase_ff, phase_in;
   logic                                   reject_ff, reject_in;

   // result register
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [uptc_pkg::RSP_TDATA_BITS-1:0]     rsp_data_ff, rsp_data_in;

   logic                                    is_term;
   logic                                    out_free;
   logic                                    byte_fire;
   logic                                    req_fire;
   logic                                    close_seg;
   logic                                    reject_now;
   logic signed [uptc_pkg::DEPTH_BITS-1:0]  depth_closed;
   logic signed [uptc_pkg::WIDE_BITS-1:0]   depth_wide;
   logic signed [uptc_pkg::FD_BITS-1:0]     final_depth;
   uptc_pkg::verdict_type                   verdict;

   assign is_term    = (byte_ff == uptc_pkg::CHAR_NUL);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign byte_fire  = byte_valid_ff && (!is_term || out_free);
   assign req_tready = !byte_valid_ff || byte_fire;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      byte_in       = byte_ff;
      if (req_fire) begin
         byte_valid_in = 1'b1;
         byte_in       = req_tdata;
      end else if (byte_fire) begin
         byte_valid_in = 1'b0;
      end
   end

   // segment close and depth update
   assign close_seg = is_term || (byte_ff == uptc_pkg::CHAR_SLASH);

   always_comb begin
      depth_closed = depth_ff;
      unique case (seg_ff)
         uptc_pkg::SEG_DOTDOT: begin
            if (depth_ff > uptc_pkg::DEPTH_MIN) begin
               depth_closed = depth_ff - uptc_pkg::DEPTH_BITS'(1);
            end
         end
         uptc_pkg::SEG_OTHER: begin
            if (depth_ff < uptc_pkg::DEPTH_MAX) begin
               depth_closed = depth_ff + uptc_pkg::DEPTH_BITS'(1);
            end
         end
         default: begin
            depth_closed = depth_ff;
         end
      endcase
   end

   assign reject_now = reject_ff ||
                       ((phase_ff == uptc_pkg::PH_SLASHDOT) &&
                        ((byte_ff == uptc_pkg::CHAR_DOT) || is_term));

   always_comb begin
      depth_in  = depth_ff;
      seg_in    = seg_ff;
      phase_in  = phase_ff;
      reject_in = reject_ff;
      if (byte_fire) begin
         unique case (phase_ff)
            uptc_pkg::PH_FIRST:
               phase_in = (byte_ff == uptc_pkg::CHAR_SLASH) ? uptc_pkg::PH_SLASH
                                                            : uptc_pkg::PH_DONE;
            uptc_pkg::PH_SLASH:
               phase_in = (byte_ff == uptc_pkg::CHAR_DOT) ? uptc_pkg::PH_SLASHDOT
                                                          : uptc_pkg::PH_DONE;
            uptc_pkg::PH_SLASHDOT:
               phase_in = uptc_pkg::PH_DONE;
            default:
               phase_in = uptc_pkg::PH_DONE;
         endcase
         reject_in = reject_now;

         if (close_seg) begin
            depth_in = depth_closed;
            seg_in   = uptc_pkg::SEG_EMPTY;
         end else if (byte_ff == uptc_pkg::CHAR_DOT) begin
            unique case (seg_ff)
               uptc_pkg::SEG_EMPTY: seg_in = uptc_pkg::SEG_DOT;
               uptc_pkg::SEG_DOT:   seg_in = uptc_pkg::SEG_DOTDOT;
               default:             seg_in = uptc_pkg::SEG_OTHER;
            endcase
         end else begin
            seg_in = uptc_pkg::SEG_OTHER;
         end

         // terminator: back to an empty path
         if (is_term) begin
            depth_in  = uptc_pkg::DEPTH_START;
            seg_in    = uptc_pkg::SEG_EMPTY;
            phase_in  = uptc_pkg::PH_FIRST;
            reject_in = 1'b0;
         end
      end
   end

   // verdict and clamped depth for the result beat
   assign depth_wide = uptc_pkg::WIDE_BITS'(depth_closed);

   always_comb begin
      if (depth_wide > uptc_pkg::FD_MAX_WIDE) begin
         final_depth = uptc_pkg::FD_MAX_WIDE[uptc_pkg::FD_BITS-1:0];
      end else if (depth_wide < uptc_pkg::FD_MIN_WIDE) begin
         final_depth = uptc_pkg::FD_MIN_WIDE[uptc_pkg::FD_BITS-1:0];
      end else begin
         final_depth = depth_wide[uptc_pkg::FD_BITS-1:0];
      end
   end

   always_comb begin
      priority if (reject_now) begin
         verdict = uptc_pkg::VERDICT_REJECT;
      end else if (depth_closed < uptc_pkg::DEPTH_START) begin
         verdict = uptc_pkg::VERDICT_REJECT;
      end else if (depth_closed == uptc_pkg::DEPTH_START) begin
         verdict = uptc_pkg::VERDICT_REWRITE;
      end else begin
         verdict = uptc_pkg::VERDICT_ACCEPT;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (byte_fire && is_term) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {{(uptc_pkg::RSP_TDATA_BITS - uptc_pkg::RSP_FIELD_BITS){1'b0}},
                         final_depth, verdict};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         depth_ff      <= uptc_pkg::DEPTH_START;
         seg_ff        <= uptc_pkg::SEG_EMPTY;
         phase_ff      <= uptc_pkg::PH_FIRST;
         reject_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         depth_ff      <= depth_in;
         seg_ff        <= seg_in;
         phase_ff      <= phase_in;
         reject_ff     <= reject_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `CHK_NEXT(a_term_clears_state, byte_fire && is_term,
      (depth_ff == uptc_pkg::DEPTH_START) && (seg_ff == uptc_pkg::SEG_EMPTY) &&
      (phase_ff == uptc_pkg::PH_FIRST) && !reject_ff,
      "path state not cleared after terminator")
   `CHK_SAME(a_verdict_legal, rsp_valid_ff,
      rsp_data_ff[uptc_pkg::VERDICT_BITS-1:0] <= uptc_pkg::VERDICT_REJECT,
      "illegal verdict code")
   `CHK_SAME(a_rewrite_depth, rsp_valid_ff &&
      (rsp_data_ff[uptc_pkg::VERDICT_BITS-1:0] == uptc_pkg::VERDICT_REWRITE),
      rsp_data_ff[uptc_pkg::RSP_FIELD_BITS-1:uptc_pkg::VERDICT_BITS] == '1,
      "rewrite verdict without depth of minus one")
   `CHK_SAME(a_accept_depth, rsp_valid_ff &&
      (rsp_data_ff[uptc_pkg::VERDICT_BITS-1:0] == uptc_pkg::VERDICT_ACCEPT),
      !rsp_data_ff[uptc_pkg::RSP_FIELD_BITS-1],
      "accept verdict with negative depth")

endmodule
